[rtl/wfp_pkg.sv]
// Shared frame parser types: step record, input stage to parser core, and
// result record, parser core to output register. No dependencies.
package wfp_pkg;

	// One result beat: a payload byte or an empty-frame marker
	typedef struct packed {
		logic [7:0] payload_byte;
		logic       data_valid;
		logic [3:0] frame_opcode;
		logic       frame_fin;
		logic       frame_end;
		logic       was_masked;
	} wfp_result_t;

	// Handoff from the input stage to the parser core
	typedef struct packed {
		logic       step;
		logic [7:0] data;
	} wfp_step_t;

endpackage

[rtl/wfp_in_stage.sv]
// Input register of the frame parser: captures one stream byte per beat.
// Depends on wfp_pkg.
module wfp_in_stage import wfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output wfp_step_t  step_o
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	// Take a new beat when empty or when the held byte moves on
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the byte until it is consumed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	assign step_o.step = valid_s1 && advance;
	assign step_o.data = byte_s1;

endmodule

[rtl/wfp_core.sv]
// Parser core: header, extended length and key state, payload unmasking.
// Depends on wfp_pkg.
module wfp_core import wfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  wfp_step_t   step_i,
	output logic        emit,
	output wfp_result_t res
);

	localparam logic [2:0] PH_HDR0   = 3'd0;
	localparam logic [2:0] PH_HDR1   = 3'd1;
	localparam logic [2:0] PH_EXTLEN = 3'd2;
	localparam logic [2:0] PH_KEY    = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	logic [2:0]  phase_q, phase_d;
	logic        fin_q, fin_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        mask_q, mask_d;
	logic [63:0] rem_q, rem_d;
	logic [3:0]  ext_q, ext_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  idx_q, idx_d;

	logic [7:0]  b;
	logic [6:0]  len7;
	logic [7:0]  kb;
	logic        emit_d;
	logic [7:0]  data_d;
	logic        last_d;

	assign b    = step_i.data;
	assign len7 = b[6:0];

	// Select the key byte for the current payload index
	always_comb begin
		unique case (idx_q)
			2'd0:    kb = key_q[31:24];
			2'd1:    kb = key_q[23:16];
			2'd2:    kb = key_q[15:8];
			default: kb = key_q[7:0];
		endcase
	end

	// Next state and result for one byte
	always_comb begin
		phase_d  = phase_q;
		fin_d    = fin_q;
		opcode_d = opcode_q;
		mask_d   = mask_q;
		rem_d    = rem_q;
		ext_d    = ext_q;
		key_d    = key_q;
		idx_d    = idx_q;
		emit_d   = 1'b0;
		data_d   = '0;
		last_d   = 1'b0;
		unique case (phase_q)
			PH_HDR0: begin
				fin_d    = b[7];
				opcode_d = b[3:0];
				phase_d  = PH_HDR1;
			end
			PH_HDR1: begin
				mask_d = b[7];
				key_d  = '0;
				idx_d  = '0;
				rem_d  = '0;
				if (len7 == LEN_EXT16) begin
					ext_d   = EXT16_BYTES;
					phase_d = PH_EXTLEN;
				end else if (len7 == LEN_EXT64) begin
					ext_d   = EXT64_BYTES;
					phase_d = PH_EXTLEN;
				end else begin
					rem_d = {57'd0, len7};
					if (b[7]) begin
						ext_d   = KEY_BYTES;
						phase_d = PH_KEY;
					end else if (len7 == 7'd0) begin
						emit_d  = 1'b1;
						last_d  = 1'b1;
						phase_d = PH_HDR0;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_EXTLEN: begin
				rem_d = {rem_q[55:0], b};
				ext_d = ext_q - 4'd1;
				if (ext_d == 4'd0) begin
					if (mask_q) begin
						ext_d   = KEY_BYTES;
						phase_d = PH_KEY;
					end else if (rem_d == 64'd0) begin
						idx_d   = '0;
						emit_d  = 1'b1;
						last_d  = 1'b1;
						phase_d = PH_HDR0;
					end else begin
						idx_d   = '0;
						phase_d = PH_DATA;
					end
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], b};
				ext_d = ext_q - 4'd1;
				if (ext_d == 4'd0) begin
					idx_d = '0;
					if (rem_q == 64'd0) begin
						emit_d  = 1'b1;
						last_d  = 1'b1;
						phase_d = PH_HDR0;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				idx_d  = idx_q + 2'd1;
				rem_d  = rem_q - 64'd1;
				last_d = (rem_q == 64'd1);
				emit_d = 1'b1;
				data_d = mask_q ? (b ^ kb) : b;
				if (last_d) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				phase_d = PH_HDR0;
			end
		endcase
	end

	// Advance the parser state on each consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			fin_q    <= 1'b0;
			opcode_q <= '0;
			mask_q   <= 1'b0;
			rem_q    <= '0;
			ext_q    <= '0;
			key_q    <= '0;
			idx_q    <= '0;
		end else if (step_i.step) begin
			phase_q  <= phase_d;
			fin_q    <= fin_d;
			opcode_q <= opcode_d;
			mask_q   <= mask_d;
			rem_q    <= rem_d;
			ext_q    <= ext_d;
			key_q    <= key_d;
			idx_q    <= idx_d;
		end
	end

	assign emit             = step_i.step && emit_d;
	assign res.payload_byte = data_d;
	assign res.data_valid   = (phase_q == PH_DATA);
	assign res.frame_opcode = opcode_d;
	assign res.frame_fin    = fin_d;
	assign res.frame_end    = last_d;
	assign res.was_masked   = mask_d;

endmodule

[rtl/wfp_out_reg.sv]
// Result register of the frame parser: holds one beat until taken.
// Depends on wfp_pkg.
module wfp_out_reg import wfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        emit,
	input  wfp_result_t res,
	output logic        advance,
	output logic        out_valid,
	input  logic        out_ready,
	output wfp_result_t out_res
);

	logic        valid_s2;
	wfp_result_t res_s2;

	// Free to load when empty or when the held beat is taken now
	assign advance = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_res   = res_s2;

endmodule

[rtl/websocket_frame_parser_unit.sv]
// Top level of the WebSocket frame parser: input register, parser core,
// result register. Depends on wfp_pkg, wfp_in_stage, wfp_core, wfp_out_reg.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | rx_byte
//  out     | out_valid / out_ready| payload_byte, data_valid, frame_opcode,
//          |                      | frame_fin, frame_end, was_masked
//
// One byte per cycle, sustained, unless a stalled output holds its beat; the
// input register keeps accepting while the result register is empty or being
// drained. Bytes pass from the input register to the result register; header,
// length and key bytes yield no beat, but an empty frame's last one yields a
// marker. Each byte's state update is one 64-bit decrement or shift plus
// compare. Reset clears the parser to expect the first header byte of a frame.
module websocket_frame_parser_unit import wfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] payload_byte,
	output logic       data_valid,
	output logic [3:0] frame_opcode,
	output logic       frame_fin,
	output logic       frame_end,
	output logic       was_masked
);

	wfp_step_t   step;
	wfp_result_t res;
	wfp_result_t out_res;
	logic        emit;
	logic        advance;

	wfp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.step_o   (step)
	);

	wfp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step_i (step),
		.emit   (emit),
		.res    (res)
	);

	wfp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.res       (res),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign payload_byte = out_res.payload_byte;
	assign data_valid   = out_res.data_valid;
	assign frame_opcode = out_res.frame_opcode;
	assign frame_fin    = out_res.frame_fin;
	assign frame_end    = out_res.frame_end;
	assign was_masked   = out_res.was_masked;

endmodule

[rtl/wfp_checker.sv]
// Port-level checks for the WebSocket frame parser, bound to the top level.
// Depends on websocket_frame_parser_unit ports only.
module wfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] payload_byte,
	input logic       data_valid,
	input logic [3:0] frame_opcode,
	input logic       frame_fin,
	input logic       frame_end,
	input logic       was_masked
);

	// Stalled result holds its beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_byte)
			&& $stable(frame_end) && $stable(data_valid))
		else $error("result beat changed while stalled");

	// Empty-frame marker carries zero data and closes the frame
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_valid |-> payload_byte == 8'd0 && frame_end)
		else $error("malformed empty-frame marker");

	// Empty result register never blocks input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// Frame attributes stay fixed on back-to-back beats of one frame
	a_frame_attr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !frame_end |=> !out_valid
			|| (frame_opcode == $past(frame_opcode) && frame_fin == $past(frame_fin)
			&& was_masked == $past(was_masked)))
		else $error("frame attributes changed inside a frame");

endmodule

bind websocket_frame_parser_unit wfp_checker u_wfp_checker (.*);
